### src/gamepad_teleop_conditioner_assert.svh
// assertion macros for the gamepad teleop conditioner
// no dependencies
`ifndef GAMEPAD_TELEOP_CONDITIONER_ASSERT_SVH
`define GAMEPAD_TELEOP_CONDITIONER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define GTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtc assertion failed");
// next-cycle implication
`define GTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtc assertion failed");
`endif

### src/gtc_pkg.sv
// package for the gamepad teleop conditioner: widths, register indexes, types
// no dependencies
package gtc_pkg;
   localparam int NumButtons = 16;
   localparam int NumAxes = 8;
   localparam int NumEntries = 4;
   localparam int NumOptions = 4;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 64;
   localparam int DivSteps = 31;

   localparam logic [CsrIdxW-1:0] RegDeadzone = 3'd0;
   localparam logic [CsrIdxW-1:0] RegAxisMap = 3'd1;
   localparam logic [CsrIdxW-1:0] RegApiCond = 3'd2;
   localparam logic [CsrIdxW-1:0] RegInBtns = 3'd3;
   localparam logic [CsrIdxW-1:0] RegInVals = 3'd4;
   localparam logic [CsrIdxW-1:0] RegSelMode = 3'd5;
   localparam logic [CsrIdxW-1:0] RegSelBtns = 3'd6;
   localparam logic [CsrIdxW-1:0] RegSelCodes = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_AXIS,
      ST_OUT
   } state_type;

   // divider start request and result
   typedef struct packed {
      logic        start;
      logic [15:0] num;   // mag - dz, up to 32768
      logic [15:0] den;   // 32768 - dz
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quot;
   } div_rsp_type;
endpackage

### src/gamepad_teleop_conditioner.sv
// top level of the gamepad teleop conditioner: checks, codes, selector, axis sequencer
// depends on gtc_pkg, gtc_divider and gamepad_teleop_conditioner_assert.svh
//
// channel | dir | fields
// req_    | in  | tdata: buttons, btn count, axis count, axis_0..axis_7
// rsp_    | out | tdata: accepted, api flag, in code, sel code, vel x/y, yaw rate, index
// csr_    | in  | write enable, index, data
//
// a word is held from acceptance until its result is taken: each of the three axes
// outside the deadzone starts the divider and waits for its 31 steps and the result,
// an axis inside it is skipped, then the output word is built and held until taken
// reset is synchronous; it clears the state, the configuration registers, last buttons and the option index
// req_tready is low from acceptance until the result word is taken
// a rejected report skips the axes and gives an all-zero word, accepted clear too
`include "gamepad_teleop_conditioner_assert.svh"
module gamepad_teleop_conditioner (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // buttons[15:0], btn count[20:16], axis count[24:21], axis_0..7 at 25+16k
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accepted[0], api flag[1], in code[17:2], sel code[33:18],
   // vel x[49:34], vel y[65:50], yaw rate[81:66], selected_index[83:82]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [gtc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [gtc_pkg::CsrDataW-1:0] csr_wdata
);
   logic [14:0] dz_ff;
   logic [11:0] amap_ff;
   logic [31:0] api_ff;
   logic [19:0] inb_ff, selb_ff;
   logic [63:0] inv_ff, selc_ff;
   logic [12:0] mode_ff;
   logic [15:0] last_ff, last_in;
   logic [1:0]  opt_ff, opt_in;

   gtc_pkg::state_type st_ff, st_in;
   logic [159:0] item_ff;
   logic [1:0]   ax_ff, ax_in;
   logic [47:0]  vel_ff, vel_in;
   logic [87:0]  out_ff, out_in;
   logic         neg_ff, neg_in, flip_ff, flip_in;
   logic         dreq_busy_ff;

   gtc_pkg::div_req_type dreq;
   gtc_pkg::div_rsp_type drsp;

   gtc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // report decode from the held word
   logic [4:0]  bcnt;
   logic [3:0]  acnt;
   logic [15:0] bmask, pressed, rising;
   logic        ok, nav, api, prv, nxt;
   logic [15:0] in_code, sel_code;
   logic [1:0]  last_opt, init_opt, opt_step;
   logic [3:0]  mentry;
   logic [15:0] raw, mag;
   logic        zero_ax;

   always_comb begin
      bcnt = (item_ff[20:16] > 5'd16) ? 5'd16 : item_ff[20:16];
      acnt = (item_ff[24:21] > 4'd8) ? 4'd8 : item_ff[24:21];
      bmask = (bcnt == 5'd16) ? 16'hFFFF : ((16'd1 << bcnt[3:0]) - 16'd1);
      pressed = item_ff[15:0] & bmask;
      nav = mode_ff[0];
      ok = 1'b1;
      for (int i = 0; i < 3; i++)
         if ({1'b0, amap_ff[4*i +: 3]} >= acnt) ok = 1'b0;
      if ((api_ff[15:0] & ~bmask) != 16'd0) ok = 1'b0;
      for (int i = 0; i < gtc_pkg::NumEntries; i++)
         if (inb_ff[5*i+4] && {1'b0, inb_ff[5*i +: 4]} >= bcnt) ok = 1'b0;
      if (nav) begin
         if ({1'b0, mode_ff[4:1]} >= bcnt) ok = 1'b0;
         if ({1'b0, mode_ff[8:5]} >= bcnt) ok = 1'b0;
      end else begin
         for (int i = 0; i < gtc_pkg::NumEntries; i++)
            if (selb_ff[5*i+4] && {1'b0, selb_ff[5*i +: 4]} >= bcnt) ok = 1'b0;
      end
      api = (api_ff[15:0] != 16'd0) &&
            (((pressed ^ api_ff[31:16]) & api_ff[15:0]) == 16'd0);
      // first match scans from the lowest priority so the first entry wins
      in_code = 16'd0;
      sel_code = 16'd0;
      for (int i = gtc_pkg::NumEntries - 1; i >= 0; i--) begin
         if (inb_ff[5*i+4] && pressed[inb_ff[5*i +: 4]]) in_code = inv_ff[16*i +: 16];
         if (selb_ff[5*i+4] && pressed[selb_ff[5*i +: 4]]) sel_code = selc_ff[16*i +: 16];
      end
      rising = pressed & ~last_ff;
      last_opt = mode_ff[10:9];
      prv = rising[mode_ff[4:1]];
      nxt = rising[mode_ff[8:5]];
      opt_step = (opt_ff > last_opt) ? last_opt : opt_ff;
      if (prv && !nxt) opt_step = (opt_step == 2'd0) ? last_opt : opt_step - 2'd1;
      else if (nxt && !prv) opt_step = (opt_step >= last_opt) ? 2'd0 : opt_step + 2'd1;
      init_opt = (csr_wdata[12:11] > csr_wdata[10:9]) ? csr_wdata[10:9] : csr_wdata[12:11];
      mentry = amap_ff[4*ax_ff +: 4];
      raw = item_ff[25 + 16*mentry[2:0] +: 16];
      mag = raw[15] ? (16'd0 - raw) : raw;
      zero_ax = mag <= {1'b0, dz_ff};
   end

   // sequencer
   always_comb begin
      st_in = st_ff;
      ax_in = ax_ff;
      vel_in = vel_ff;
      out_in = out_ff;
      neg_in = neg_ff;
      flip_in = flip_ff;
      last_in = last_ff;
      opt_in = opt_ff;
      dreq.start = 1'b0;
      dreq.num = mag - {1'b0, dz_ff};
      dreq.den = 16'h8000 - {1'b0, dz_ff};
      req_tready = 1'b0;
      unique case (st_ff)
         gtc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               st_in = gtc_pkg::ST_AXIS;
               ax_in = 2'd0;
               vel_in = '0;
            end
         end
         gtc_pkg::ST_AXIS: begin
            if (!ok) begin
               out_in = '0;
               st_in = gtc_pkg::ST_OUT;
            end else if (drsp.done) begin
               vel_in[16*ax_ff +: 16] = (neg_ff != flip_ff) ?
                  16'd0 - ((drsp.quot > 17'd32767) ? 16'h7FFF : drsp.quot[15:0]) :
                  ((drsp.quot > 17'd32767) ? 16'h7FFF : drsp.quot[15:0]);
               ax_in = ax_ff + 2'd1;
            end else if (!dreq_busy_ff) begin
               if (ax_ff == 2'd3) begin
                  if (nav) opt_in = opt_step;
                  last_in = pressed;
                  out_in = {4'd0, nav ? opt_step : opt_ff, vel_ff,
                            nav ? selc_ff[16*opt_step +: 16] : sel_code,
                            in_code, api, 1'b1};
                  st_in = gtc_pkg::ST_OUT;
               end else if (zero_ax) begin
                  ax_in = ax_ff + 2'd1;
               end else begin
                  dreq.start = 1'b1;
                  neg_in = raw[15];
                  flip_in = mentry[3];
               end
            end
         end
         gtc_pkg::ST_OUT: begin
            if (rsp_tready) st_in = gtc_pkg::ST_IDLE;
         end
         default: st_in = gtc_pkg::ST_IDLE;
      endcase
      if (csr_wen && csr_index == gtc_pkg::RegSelMode) opt_in = init_opt;
   end

   // divider busy tracking
   always_ff @(posedge clock) begin
      if (reset) dreq_busy_ff <= 1'b0;
      else if (dreq.start) dreq_busy_ff <= 1'b1;
      else if (drsp.done) dreq_busy_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= gtc_pkg::ST_IDLE;
         dz_ff <= '0; amap_ff <= '0; api_ff <= '0; inb_ff <= '0;
         inv_ff <= '0; mode_ff <= '0; selb_ff <= '0; selc_ff <= '0;
         last_ff <= '0; opt_ff <= '0; ax_ff <= '0;
      end else begin
         st_ff <= st_in;
         ax_ff <= ax_in;
         last_ff <= last_in;
         opt_ff <= opt_in;
         if (csr_wen) begin
            unique case (csr_index)
               gtc_pkg::RegDeadzone: dz_ff <= csr_wdata[14:0];
               gtc_pkg::RegAxisMap:  amap_ff <= csr_wdata[11:0];
               gtc_pkg::RegApiCond:  api_ff <= csr_wdata[31:0];
               gtc_pkg::RegInBtns:   inb_ff <= csr_wdata[19:0];
               gtc_pkg::RegInVals:   inv_ff <= csr_wdata;
               gtc_pkg::RegSelMode:  mode_ff <= csr_wdata[12:0];
               gtc_pkg::RegSelBtns:  selb_ff <= csr_wdata[19:0];
               gtc_pkg::RegSelCodes: selc_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) item_ff <= req_tdata;
      vel_ff <= vel_in;
      out_ff <= out_in;
      neg_ff <= neg_in;
      flip_ff <= flip_in;
   end

   assign rsp_tvalid = (st_ff == gtc_pkg::ST_OUT);
   assign rsp_tdata = out_ff;

   `GTC_ASSERT_IMPL(a_ready_idle, clock, reset, req_tready, !rsp_tvalid)
   `GTC_ASSERT_IMPL(a_div_only_axis, clock, reset, dreq.start, st_ff == gtc_pkg::ST_AXIS)
   `GTC_ASSERT_NEXT(a_hold_out, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
endmodule

### src/gtc_divider.sv
// shared restoring divider: (num << 15) / den, one quotient bit a cycle
// depends on gtc_pkg
module gtc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gtc_pkg::div_req_type req,
   output gtc_pkg::div_rsp_type rsp
);
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] rem_ff, rem_in;
   logic [30:0] dvd_ff, dvd_in;
   logic [16:0] quot_ff, quot_in;
   logic [16:0] trial;
   logic        done_ff, done_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quot_in = quot_ff;
      done_in = 1'b0;
      trial = {rem_ff[15:0], dvd_ff[30]} - {1'b0, req.den};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 5'd0;
         rem_in = '0;
         dvd_in = {req.num[15:0], 15'd0};
         quot_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[29:0], 1'b0};
         if (!trial[16]) begin
            rem_in = trial;
            quot_in = {quot_ff[15:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], dvd_ff[30]};
            quot_in = {quot_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(gtc_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
endmodule
